>>> src/modular_fraction_accumulator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular fraction accumulator
// Shared clocked property forms used by the controller and the top level.
// ---------------------------------------------------------------------------
`ifndef MODULAR_FRACTION_ACCUMULATOR_TOP_DEFINES_SVH
`define MODULAR_FRACTION_ACCUMULATOR_TOP_DEFINES_SVH

// implication checked at every edge outside reset
`define MFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfa check failed");

// next-cycle implication checked outside reset
`define MFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfa check failed");

`endif

>>> src/mfa_pkg.sv
// ---------------------------------------------------------------------------
// mfa_pkg
// Widths, command and status types shared by the accumulator modules.
// ---------------------------------------------------------------------------
`default_nettype none
package mfa_pkg;
  localparam int OPERAND_WIDTH = 31;
  localparam int MW            = 31;
  localparam int CW            = 16;
  localparam int PW            = 2 * MW;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch operands, reduce residues
    OP_DIVX,      // start x / M
    OP_STRIP,     // accept quotient, step count
    OP_FOLDX,     // start residue * (x mod M) mod M
    OP_SELD,      // select divisor as x
    OP_INV,       // start inverse of den residue
    OP_NORM,      // start num * inv mod M
    OP_FIN        // den := 1
  } op_t;

  typedef struct packed {
    op_t  op;
    logic up;     // count direction / target residue
  } cmd_t;

  typedef struct packed {
    logic busy;        // datapath unit or divider running
    logic x_divisible; // last x / M gave remainder 0
    logic cnt_pos;
    logic cnt_neg;
    logic mod_bad;
    logic zero_op;
  } sts_t;
endpackage
`default_nettype wire

>>> src/mfa_divider.sv
// ---------------------------------------------------------------------------
// mfa_divider
// Restoring divider, one quotient bit per cycle, 62-bit dividend.
// ---------------------------------------------------------------------------
`default_nettype none
module mfa_divider (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [mfa_pkg::PW-1:0]  dividend,
  input  wire logic [mfa_pkg::MW-1:0]  divisor,
  output logic                         busy,
  output logic [mfa_pkg::PW-1:0]       quot,
  output logic [mfa_pkg::MW-1:0]       rem
);
  localparam int NW = $clog2(mfa_pkg::PW + 1);
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic [mfa_pkg::PW-1:0] q_r, q_nxt;
  logic [mfa_pkg::MW:0]   r_r, r_nxt;
  logic [mfa_pkg::MW-1:0] d_r;
  logic [mfa_pkg::MW:0]   trial;

  assign busy  = (cnt_r != '0);
  assign quot  = q_r;
  assign rem   = r_r[mfa_pkg::MW-1:0];
  assign trial = {r_r[mfa_pkg::MW-1:0], q_r[mfa_pkg::PW-1]};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    r_nxt   = r_r;
    if (start) begin
      cnt_nxt = NW'(mfa_pkg::PW);
      q_nxt   = dividend;
      r_nxt   = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[mfa_pkg::PW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[mfa_pkg::PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= divisor;
  end
endmodule
`default_nettype wire

>>> src/mfa_datapath.sv
// ---------------------------------------------------------------------------
// mfa_datapath
// Residues, count, shared divider and the extended-Euclid sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module mfa_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mfa_pkg::cmd_t          cmd,
  input  wire logic [mfa_pkg::MW-1:0] modulus,
  input  wire logic [mfa_pkg::MW-1:0] mul_factor,
  input  wire logic [mfa_pkg::MW-1:0] div_factor,
  output mfa_pkg::sts_t               sts,
  output logic [mfa_pkg::MW-1:0]      num_out
);
  localparam int MW = mfa_pkg::MW;
  localparam int PW = mfa_pkg::PW;
  localparam int CW = mfa_pkg::CW;

  typedef enum logic [2:0] {
    U_IDLE, U_RED, U_DIVX, U_MUL, U_EUC, U_EUCW, U_NORM
  } unit_t;

  unit_t unit_r;
  logic [MW-1:0] num_r, den_r, df_r, x_r, inv_r, fold_r;
  logic signed [CW-1:0] cnt_r;
  logic [1:0] red_r;          // residue reduction progress
  logic tgt_r;                // product target: 1 num, 0 den
  logic divis_r;
  // Euclid registers, t values kept signed at MW+2 bits
  logic [MW-1:0] r0_r, r1_r;
  logic signed [MW+1:0] t0_r, t1_r;

  logic          dv_start, dv_busy;
  logic [PW-1:0] dv_dend, dv_quot;
  logic [MW-1:0] dv_sor, dv_rem;
  logic [PW-1:0] prod;
  logic signed [MW+1:0] qt;
  logic signed [MW+1:0] t2, tfix;

  mfa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dend),
    .divisor(dv_sor), .busy(dv_busy), .quot(dv_quot), .rem(dv_rem)
  );

  // Euclid quotients never exceed the modulus, so only the low MW bits count
  assign dv_sor = (unit_r == U_EUC) ? r1_r : modulus;
  assign qt   = $signed({2'b0, dv_quot[MW-1:0]}) * t1_r;
  assign t2   = t0_r - qt;
  assign tfix = t0_r[MW+1] ? t0_r + $signed({2'b0, modulus}) : t0_r;

  always_comb begin
    dv_start = 1'b0;
    dv_dend  = '0;
    case (cmd.op)
      mfa_pkg::OP_LOAD: begin
        dv_start = 1'b1;
        dv_dend  = PW'(num_r);
      end
      mfa_pkg::OP_DIVX: begin
        dv_start = 1'b1;
        dv_dend  = PW'(x_r);
      end
      mfa_pkg::OP_FOLDX: begin
        dv_start = 1'b1;
        dv_dend  = PW'(x_r);
      end
      mfa_pkg::OP_NORM: begin
        dv_start = 1'b1;
        dv_dend  = PW'(num_r) * PW'(inv_r);
      end
      default: begin
        dv_start = 1'b0;
      end
    endcase
    if (cmd.op == mfa_pkg::OP_NONE && unit_r == U_RED && !dv_busy && red_r == 2'd1) begin
      dv_start = 1'b1;
      dv_dend  = PW'(den_r);
    end
    if (cmd.op == mfa_pkg::OP_NONE && unit_r == U_MUL && !dv_busy && red_r == 2'd1) begin
      dv_start = 1'b1;
      dv_dend  = prod;
    end
    if (cmd.op == mfa_pkg::OP_NONE && unit_r == U_EUC && !dv_busy && r1_r != '0) begin
      dv_start = 1'b1;
      dv_dend  = PW'(r0_r);
    end
  end

  assign prod = PW'(fold_r) * PW'(tgt_r ? num_r : den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= U_IDLE;
      num_r  <= MW'(1);
      den_r  <= MW'(1);
      cnt_r  <= '0;
      red_r  <= '0;
    end else begin
      case (cmd.op)
        mfa_pkg::OP_LOAD: begin
          df_r   <= div_factor;
          x_r    <= mul_factor;
          unit_r <= U_RED;
          red_r  <= 2'd0;
        end
        mfa_pkg::OP_DIVX: begin
          unit_r <= U_DIVX;
        end
        mfa_pkg::OP_STRIP: begin
          x_r <= dv_quot[MW-1:0];
          if (cmd.up) begin
            if (cnt_r != {1'b0, {(CW-1){1'b1}}}) cnt_r <= cnt_r + 1'b1;
          end else begin
            if (cnt_r != {1'b1, {(CW-1){1'b0}}}) cnt_r <= cnt_r - 1'b1;
          end
        end
        mfa_pkg::OP_FOLDX: begin
          tgt_r  <= cmd.up;
          unit_r <= U_MUL;
          red_r  <= 2'd0;
        end
        mfa_pkg::OP_SELD: begin
          x_r <= df_r;
        end
        mfa_pkg::OP_INV: begin
          r0_r   <= modulus;
          r1_r   <= den_r;
          t0_r   <= '0;
          t1_r   <= (MW+2)'(1);
          unit_r <= U_EUC;
        end
        mfa_pkg::OP_NORM: begin
          unit_r <= U_NORM;
        end
        mfa_pkg::OP_FIN: begin
          den_r <= MW'(1);
        end
        default: begin
          case (unit_r)
            U_RED: if (!dv_busy) begin
              // reduce num then den modulo the current modulus
              if (red_r == 2'd0) begin
                red_r <= 2'd1;
              end else if (red_r == 2'd1) begin
                red_r <= 2'd2;
                num_r <= dv_rem;
              end else begin
                den_r  <= dv_rem;
                unit_r <= U_IDLE;
              end
            end
            U_DIVX: if (!dv_busy) begin
              divis_r <= (dv_rem == '0);
              unit_r  <= U_IDLE;
            end
            U_MUL: if (!dv_busy) begin
              if (red_r == 2'd0) begin
                fold_r <= dv_rem;
                red_r  <= 2'd1;
              end else if (red_r == 2'd1) begin
                red_r <= 2'd2;
              end else begin
                if (tgt_r) num_r <= dv_rem;
                else       den_r <= dv_rem;
                unit_r <= U_IDLE;
              end
            end
            U_EUC: if (!dv_busy) begin
              if (r1_r == '0) begin
                inv_r  <= (r0_r == MW'(1)) ? tfix[MW-1:0] : '0;
                unit_r <= U_IDLE;
              end else begin
                unit_r <= U_EUCW;
              end
            end
            U_EUCW: if (!dv_busy) begin
              r0_r   <= r1_r;
              r1_r   <= dv_rem;
              t0_r   <= t1_r;
              t1_r   <= t2;
              unit_r <= U_EUC;
            end
            U_NORM: if (!dv_busy) begin
              num_r  <= dv_rem;
              unit_r <= U_IDLE;
            end
            default: unit_r <= U_IDLE;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    sts.busy        = (unit_r != U_IDLE) || dv_busy;
    sts.x_divisible = divis_r;
    sts.cnt_pos     = !cnt_r[CW-1] && (cnt_r != '0);
    sts.cnt_neg     = cnt_r[CW-1];
    sts.mod_bad     = (modulus < MW'(2));
    sts.zero_op     = (mul_factor == '0) || (div_factor == '0);
  end
  assign num_out = num_r;
endmodule
`default_nettype wire

>>> src/mfa_ctrl.sv
// ---------------------------------------------------------------------------
// mfa_ctrl
// Sequencer: strip, fold, invert and normalize, then hand over the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "modular_fraction_accumulator_top_defines.svh"
module mfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_accept,
  input  wire logic          out_accept,
  input  wire mfa_pkg::sts_t sts,
  output mfa_pkg::cmd_t      cmd,
  output logic               idle,
  output logic               done,
  output logic               skip
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIV, S_TEST, S_FOLD, S_INV, S_NORM, S_FIN, S_DONE
  } state_t;

  state_t state_r;
  logic   dir_r;
  logic   skip_r;

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign skip = skip_r;

  always_comb begin
    cmd.op = mfa_pkg::OP_NONE;
    cmd.up = dir_r;
    case (state_r)
      S_IDLE: if (in_accept && !sts.mod_bad && !sts.zero_op) cmd.op = mfa_pkg::OP_LOAD;
      S_DIV:  if (!sts.busy) cmd.op = mfa_pkg::OP_DIVX;
      S_TEST: if (!sts.busy) begin
        cmd.op = sts.x_divisible ? mfa_pkg::OP_STRIP : mfa_pkg::OP_FOLDX;
      end
      S_FOLD: if (!sts.busy) begin
        if (dir_r) cmd.op = mfa_pkg::OP_SELD;
        else if (!sts.cnt_pos && !sts.cnt_neg) cmd.op = mfa_pkg::OP_INV;
      end
      S_INV:  if (!sts.busy) cmd.op = mfa_pkg::OP_NORM;
      S_NORM: if (!sts.busy) cmd.op = mfa_pkg::OP_FIN;
      default: cmd.op = mfa_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dir_r   <= 1'b1;
      skip_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_accept) begin
          dir_r <= 1'b1;
          if (sts.mod_bad || sts.zero_op) begin
            skip_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            skip_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV:  if (!sts.busy) state_r <= S_TEST;
        S_TEST: if (!sts.busy) state_r <= sts.x_divisible ? S_DIV : S_FOLD;
        S_FOLD: if (!sts.busy) begin
          if (dir_r) begin
            dir_r   <= 1'b0;
            state_r <= S_DIV;
          end else if (!sts.cnt_pos && !sts.cnt_neg) begin
            state_r <= S_INV;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_INV:  if (!sts.busy) state_r <= S_NORM;
        S_NORM: if (!sts.busy) state_r <= S_FIN;
        S_FIN:  state_r <= S_DONE;
        S_DONE: if (out_accept) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `MFA_ASSERT_IMP(a_accept_only_idle, in_accept, state_r == S_IDLE)
  `MFA_ASSERT_IMP(a_out_only_done, out_accept, state_r == S_DONE)
  `MFA_ASSERT_NEXT(a_done_to_idle, done && out_accept, state_r == S_IDLE)
endmodule
`default_nettype wire

>>> src/modular_fraction_accumulator_top.sv
// A refused item (zero operand or modulus below two) raises out_valid in the cycle after
// accept. Otherwise the work is a series of passes through the shared 62-bit restoring
// divider: two to reduce the residues, three per operand for the last test and the fold,
// one per modulus factor stripped, one per Euclid step (up to ~45) and one to normalize.
// One item in flight; the next beat is taken after the result.
// Reset (rst_n low, synchronous): modulus 2, residues 1, factor count 0, no result held.
`default_nettype none
`include "modular_fraction_accumulator_top_defines.svh"
// ---------------------------------------------------------------------------
// modular_fraction_accumulator_top
// Running fraction modulo a prime: strips modulus factors from each multiplier
// and divisor, folds the rest into residues and normalizes via an inverse.
// ---------------------------------------------------------------------------
module modular_fraction_accumulator_top (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [mfa_pkg::MW-1:0] cfg_modulus,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [mfa_pkg::MW-1:0] in_mul_factor,
  input  wire logic [mfa_pkg::MW-1:0] in_div_factor,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [mfa_pkg::MW-1:0]      out_value,
  output logic                        out_has_modulus_factor,
  output logic                        out_error
);
  logic [mfa_pkg::MW-1:0] modulus_r;
  logic                   in_acc, out_acc, idle, done, skip;
  mfa_pkg::cmd_t          cmd;
  mfa_pkg::sts_t          sts;
  logic [mfa_pkg::MW-1:0] num;

  // the input beat is held by the sender while stalled, so operands stay
  // readable on the ports through the load cycle
  assign in_stall = !idle;
  assign in_acc   = in_valid && idle;
  assign out_acc  = done && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mfa_pkg::MW'(2);
    end else if (cfg_we) begin
      modulus_r <= cfg_modulus;
    end
  end

  mfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_accept(in_acc), .out_accept(out_acc),
    .sts(sts), .cmd(cmd), .idle(idle), .done(done), .skip(skip)
  );

  mfa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .modulus(modulus_r),
    .mul_factor(in_mul_factor), .div_factor(in_div_factor),
    .sts(sts), .num_out(num)
  );

  // result fields follow the count; hold while done and stalled
  assign out_valid = done;
  always_comb begin
    out_value              = '0;
    out_has_modulus_factor = 1'b0;
    out_error              = 1'b0;
    if (sts.mod_bad && skip) begin
      out_error = 1'b1;
    end else if (skip) begin
      out_error              = 1'b1;
      out_has_modulus_factor = sts.cnt_pos;
    end else if (sts.cnt_pos) begin
      out_has_modulus_factor = 1'b1;
    end else if (sts.cnt_neg) begin
      out_error = 1'b1;
    end else begin
      out_value = num;
    end
  end

  `MFA_ASSERT_IMP(a_no_accept_while_done, out_valid, in_stall)
  `MFA_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid)
  `MFA_ASSERT_IMP(a_value_zero_on_error, out_valid && out_error, out_value == '0)
endmodule
`default_nettype wire
